/* sv/jdd_pkg.sv */
`default_nettype none
package jdd_pkg;

	localparam int JOB_DEPTH_DEF = 64;
	localparam int USERS_DEF     = 16;
	localparam int MAX_SLOTS_DEF = 8;
	localparam int OUT_MAX       = 8;
	localparam int CMD_W         = 32;
	localparam int USER_W        = 4;
	localparam int LIMIT_W       = 4;
	localparam int CFG_IDX_W     = 4;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAR = 4'd1;

	typedef enum logic [1:0] {
		STAT_DISPATCHED  = 2'd0,
		STAT_ACK         = 2'd1,
		STAT_FULL        = 2'd2,
		STAT_NOT_RUNNING = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB_RD,
		ST_SUB_WR,
		ST_FIN,
		ST_DSP,
		ST_DSP_WB,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic             clr;
		logic             set;
		logic [CMD_W-1:0] cmd;
	} slot_op_t;

endpackage
`default_nettype wire

/* sv/jdd_ram.sv */
`default_nettype none
module jdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

/* sv/jdd_slots.sv */
`default_nettype none
module jdd_slots import jdd_pkg::*; #(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire slot_op_t op,
	output logic          hit
);

	logic             valid_q [MAX_SLOTS];
	logic [CMD_W-1:0] cmd_q   [MAX_SLOTS];
	logic [MAX_SLOTS-1:0] clr_sel;
	logic [MAX_SLOTS-1:0] set_sel;

	always_comb begin
		logic found;
		logic got;
		found   = 1'b0;
		got     = 1'b0;
		clr_sel = '0;
		set_sel = '0;
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (!found && valid_q[s] && cmd_q[s] == op.cmd) begin
				clr_sel[s] = 1'b1;
				found      = 1'b1;
			end
			if (!got && !valid_q[s]) begin
				set_sel[s] = 1'b1;
				got        = 1'b1;
			end
		end
		hit = found;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < MAX_SLOTS; s++) begin
				valid_q[s] <= 1'b0;
			end
		end else begin
			for (int s = 0; s < MAX_SLOTS; s++) begin
				if (op.clr && clr_sel[s]) begin
					valid_q[s] <= 1'b0;
				end else if (op.set && set_sel[s]) begin
					valid_q[s] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int s = 0; s < MAX_SLOTS; s++) begin
			if (op.set && set_sel[s]) begin
				cmd_q[s] <= op.cmd;
			end
		end
	end

endmodule
`default_nettype wire

/* sv/job_dispatcher_fcfs_user_rr_unit.sv */
`default_nettype none
// Job dispatcher with a cap on running jobs. Each input is a submit (mode 0) or a finish
// (mode 1). Pending jobs wait in one first-come queue (policy 0) or in per-user queues served
// round robin (policy 1); jobs live in a job store memory with a link memory beside it. After
// each accepted submit or matched finish, jobs are dispatched while fewer than
// min(run limit, MAX_SLOTS) run, at most 8 per input; one result per dispatched job, or one
// acknowledgement/error result, and all_idle is valid on every result. After its transfer a
// submit passes through a store read, a store write and a final dispatch check before its
// results, and a finish through a slot lookup and a final dispatch check; each dispatched job
// adds a memory read and a write-back, and the dispatch check skips empty users on the ring. A
// rejected submit or an unknown finish goes straight to its result. Results leave in order, each
// held until out_ready takes it, and the unit then returns to idle. No input is taken until all
// results of the previous one are out. The configuration port is always ready; write it only
// while idle.
module job_dispatcher_fcfs_user_rr_unit import jdd_pkg::*; #(
	parameter int JOB_DEPTH = JOB_DEPTH_DEF,
	parameter int USERS     = USERS_DEF,
	parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [LIMIT_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 mode,
	input  wire logic [USER_W-1:0]    user_id,
	input  wire logic [CMD_W-1:0]     job_tag,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [1:0]                status,
	output logic [USER_W-1:0]         user_id_out,
	output logic [CMD_W-1:0]          job_tag_out,
	output logic                      last,
	output logic                      all_idle
);

	localparam int JW   = $clog2(JOB_DEPTH);
	localparam int UW   = (USERS > 1) ? $clog2(USERS) : 1;
	localparam int RCW  = $clog2(USERS + 1);
	localparam int PW   = RCW + 1;
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
	localparam int NW   = $clog2(OUT_MAX + 1);
	localparam int KW   = $clog2(OUT_MAX);
	localparam int DW   = USER_W + CMD_W;

	state_t state_q, state_d;

	logic [USER_W-1:0]   user_q;
	logic [CMD_W-1:0]    cmd_q;
	logic                policy_q;
	logic [LIMIT_W-1:0]  max_par_q;

	logic [JW-1:0] free_head_q;
	logic [JW:0]   free_cnt_q, fill_q, pending_q;
	logic [JW-1:0] fifo_head_q, fifo_tail_q;
	logic [JW:0]   fifo_cnt_q;
	logic [JW-1:0] uq_head_q [USERS];
	logic [JW-1:0] uq_tail_q [USERS];
	logic [JW:0]   uq_cnt_q  [USERS];
	logic [UW-1:0] ring_q    [USERS];
	logic [UW-1:0] ring_head_q;
	logic [RCW-1:0] ring_cnt_q;
	logic [CW-1:0] running_q;

	logic [JW-1:0] sel_idx_q;
	logic [UW-1:0] sel_u_q;
	logic [NW-1:0] n_q;
	logic [KW-1:0] k_q;
	status_t       code_q;
	logic [USER_W-1:0] res_user_q [OUT_MAX];
	logic [CMD_W-1:0]  res_cmd_q  [OUT_MAX];

	logic [UW-1:0] umod [2**USER_W];
	logic [UW-1:0] u_in, ring_front, ring_tail, ring_head_inc;
	logic [PW-1:0] ring_sum;
	logic [JW-1:0] head_inc, dsp_idx;
	logic          virgin, can_run, have_job, dsp_go, hit;

	logic          link_we, data_we;
	logic [JW-1:0] link_waddr, link_wdata, link_raddr, link_rdata;
	logic [DW-1:0] data_rdata;
	slot_op_t      slot_op;

	always_comb begin
		for (int i = 0; i < 2**USER_W; i++) begin
			umod[i] = UW'(i % USERS);
		end
	end

	assign u_in          = umod[user_q];
	assign ring_front    = ring_q[ring_head_q];
	assign ring_sum      = PW'(ring_head_q) + PW'(ring_cnt_q);
	assign ring_tail     = (ring_sum >= PW'(USERS)) ? UW'(ring_sum - PW'(USERS)) : UW'(ring_sum);
	assign ring_head_inc = (ring_head_q == UW'(USERS - 1)) ? '0 : ring_head_q + 1'b1;
	assign virgin        = ({1'b0, free_head_q} == fill_q);
	assign head_inc      = (free_head_q == JW'(JOB_DEPTH - 1)) ? '0 : free_head_q + 1'b1;
	assign dsp_idx       = policy_q ? uq_head_q[ring_front] : fifo_head_q;
	assign can_run       = (CMPW'(running_q) < CMPW'(max_par_q)) &&
	                       (running_q < CW'(MAX_SLOTS));
	assign have_job      = policy_q ? (ring_cnt_q != '0) : (fifo_cnt_q != '0);
	assign dsp_go        = (n_q < NW'(OUT_MAX)) && can_run && have_job;

	always_comb begin
		link_we    = 1'b0;
		link_waddr = free_head_q;
		link_wdata = free_head_q;
		data_we    = 1'b0;
		link_raddr = (state_q == ST_SUB_RD) ? free_head_q : dsp_idx;
		if (state_q == ST_SUB_WR) begin
			data_we    = 1'b1;
			link_wdata = free_head_q;
			if (!policy_q) begin
				link_we    = (fifo_cnt_q != '0);
				link_waddr = fifo_tail_q;
			end else begin
				link_we    = (uq_cnt_q[u_in] != '0);
				link_waddr = uq_tail_q[u_in];
			end
		end else if (state_q == ST_DSP_WB) begin
			link_we    = 1'b1;
			link_waddr = sel_idx_q;
			link_wdata = free_head_q;
		end
		slot_op.clr = (state_q == ST_FIN) && hit;
		slot_op.set = (state_q == ST_DSP_WB);
		slot_op.cmd = (state_q == ST_DSP_WB) ? data_rdata[CMD_W-1:0] : cmd_q;
	end

	jdd_ram #(.WIDTH(JW), .DEPTH(JOB_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	jdd_ram #(.WIDTH(DW), .DEPTH(JOB_DEPTH)) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (free_head_q),
		.wdata ({user_q, cmd_q}),
		.raddr (dsp_idx),
		.rdata (data_rdata)
	);

	jdd_slots #(.MAX_SLOTS(MAX_SLOTS)) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (slot_op),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = mode ? ST_FIN : ST_SUB_RD;
				end
			end
			ST_SUB_RD: state_d = (free_cnt_q == '0) ? ST_OUT : ST_SUB_WR;
			ST_SUB_WR: state_d = ST_DSP;
			ST_FIN:    state_d = hit ? ST_DSP : ST_OUT;
			ST_DSP: begin
				if (!dsp_go) begin
					state_d = ST_OUT;
				end else if (!policy_q && 1'b1) begin
					state_d = ST_DSP_WB;
				end else if (uq_cnt_q[ring_front] != '0) begin
					state_d = ST_DSP_WB;
				end
			end
			ST_DSP_WB: state_d = ST_DSP;
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready && last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= 1'b0;
			max_par_q   <= LIMIT_W'(1);
			free_head_q <= '0;
			free_cnt_q  <= (JW+1)'(JOB_DEPTH);
			fill_q      <= '0;
			pending_q   <= '0;
			fifo_cnt_q  <= '0;
			ring_head_q <= '0;
			ring_cnt_q  <= '0;
			running_q   <= '0;
			n_q         <= '0;
			k_q         <= '0;
			code_q      <= STAT_ACK;
			for (int i = 0; i < USERS; i++) begin
				uq_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_POLICY:  policy_q  <= cfg_data[0];
					REG_MAX_PAR: max_par_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					n_q    <= '0;
					k_q    <= '0;
					code_q <= STAT_ACK;
				end
				ST_SUB_RD: begin
					if (free_cnt_q == '0) begin
						code_q <= STAT_FULL;
					end
				end
				ST_SUB_WR: begin
					free_head_q <= virgin ? head_inc : link_rdata;
					fill_q      <= virgin ? fill_q + 1'b1 : fill_q;
					free_cnt_q  <= free_cnt_q - 1'b1;
					pending_q   <= pending_q + 1'b1;
					if (!policy_q) begin
						fifo_cnt_q <= fifo_cnt_q + 1'b1;
					end else begin
						uq_cnt_q[u_in] <= uq_cnt_q[u_in] + 1'b1;
						if (uq_cnt_q[u_in] == '0 && ring_cnt_q < RCW'(USERS)) begin
							ring_cnt_q <= ring_cnt_q + 1'b1;
						end
					end
				end
				ST_FIN: begin
					if (hit) begin
						running_q <= running_q - 1'b1;
					end else begin
						code_q <= STAT_NOT_RUNNING;
					end
				end
				ST_DSP: begin
					if (dsp_go && policy_q) begin
						ring_head_q <= ring_head_inc;
						ring_cnt_q  <= ring_cnt_q - 1'b1;
					end
				end
				ST_DSP_WB: begin
					running_q   <= running_q + 1'b1;
					pending_q   <= pending_q - 1'b1;
					free_cnt_q  <= free_cnt_q + 1'b1;
					free_head_q <= sel_idx_q;
					n_q         <= n_q + 1'b1;
					if (!policy_q) begin
						fifo_cnt_q <= fifo_cnt_q - 1'b1;
					end else begin
						uq_cnt_q[sel_u_q] <= uq_cnt_q[sel_u_q] - 1'b1;
						if (uq_cnt_q[sel_u_q] > (JW+1)'(1)) begin
							ring_cnt_q <= ring_cnt_q + 1'b1;
						end
					end
				end
				ST_OUT: begin
					if (out_ready && !last) begin
						k_q <= k_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					user_q <= user_id;
					cmd_q  <= job_tag;
				end
			end
			ST_SUB_WR: begin
				if (!policy_q) begin
					if (fifo_cnt_q == '0) begin
						fifo_head_q <= free_head_q;
					end
					fifo_tail_q <= free_head_q;
				end else begin
					if (uq_cnt_q[u_in] == '0) begin
						uq_head_q[u_in] <= free_head_q;
						if (ring_cnt_q < RCW'(USERS)) begin
							ring_q[ring_tail] <= u_in;
						end
					end
					uq_tail_q[u_in] <= free_head_q;
				end
			end
			ST_DSP: begin
				sel_idx_q <= dsp_idx;
				sel_u_q   <= ring_front;
			end
			ST_DSP_WB: begin
				res_user_q[n_q[KW-1:0]] <= data_rdata[DW-1:CMD_W];
				res_cmd_q[n_q[KW-1:0]]  <= data_rdata[CMD_W-1:0];
				if (!policy_q) begin
					fifo_head_q <= link_rdata;
				end else begin
					uq_head_q[sel_u_q] <= link_rdata;
					if (uq_cnt_q[sel_u_q] > (JW+1)'(1)) begin
						ring_q[ring_tail] <= sel_u_q;
					end
				end
			end
			default: ;
		endcase
	end

	assign cfg_ready   = 1'b1;
	assign status      = (n_q == '0) ? code_q : STAT_DISPATCHED;
	assign user_id_out = (n_q == '0) ? '0 : res_user_q[k_q];
	assign job_tag_out = (n_q == '0) ? '0 : res_cmd_q[k_q];
	assign last        = (n_q == '0) || ((NW'(k_q) + 1'b1) == n_q);
	assign all_idle    = (pending_q == '0) && (running_q == '0);

	a_running_cap: assert property (@(posedge clk) disable iff (!arst_n)
		running_q <= CW'(MAX_SLOTS))
		else $error("running count above slot count");

	a_store_balance: assert property (@(posedge clk) disable iff (!arst_n)
		((JW+2)'(free_cnt_q) + (JW+2)'(pending_q)) == (JW+2)'(JOB_DEPTH))
		else $error("free and pending jobs do not add up to store depth");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_DISPATCHED |-> last)
		else $error("non-dispatch result not marked last");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result shown in the cycle after a transfer in");

endmodule
`default_nettype wire
